// ----- rtl/uartr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uartr_pkg
// Types, register codes and interrupt helpers for the UART register block.
// ----------------------------------------------------------------------------
package uartr_pkg;

  // request kinds
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // register offsets
  localparam logic [2:0] OFS_RBR_DLL = 3'd0;
  localparam logic [2:0] OFS_IER_DLH = 3'd1;
  localparam logic [2:0] OFS_IIR_FCR = 3'd2;
  localparam logic [2:0] OFS_LCR     = 3'd3;
  localparam logic [2:0] OFS_LSR     = 3'd5;
  localparam logic [2:0] OFS_MSR     = 3'd6;

  // interrupt identification codes
  localparam logic [3:0] ID_NONE = 4'h1;
  localparam logic [3:0] ID_MSI  = 4'h0;
  localparam logic [3:0] ID_THR  = 4'h2;
  localparam logic [3:0] ID_RD   = 4'h4;
  localparam logic [3:0] ID_RLS  = 4'h6;
  localparam logic [3:0] ID_TO   = 4'hC;

  // pending source bits
  localparam logic [1:0] SRC_NONE = 2'b00;
  localparam logic [1:0] SRC_TO   = 2'b01;
  localparam logic [1:0] SRC_THR  = 2'b10;

  localparam logic [7:0] LCR_RESET = 8'h03;
  localparam logic [7:0] LSR_FIXED = 8'h60;
  localparam logic [7:0] IIR_TOP   = 8'hC0;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_offset;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_level;
  } result_t;

  typedef struct packed {
    logic [3:0] ident;
    logic [1:0] pend;
    logic       irq;
  } irq_t;

  function automatic irq_t raise_rx(irq_t s, logic [3:0] en);
    irq_t r;
    r = s;
    r.pend = s.pend | SRC_TO;
    if (en[0] && s.ident != ID_RLS && s.ident != ID_RD) begin
      r.ident = ID_TO;
      r.irq   = 1'b1;
    end
    return r;
  endfunction

  function automatic irq_t raise_tx(irq_t s, logic [3:0] en);
    irq_t r;
    r = s;
    r.pend = s.pend | SRC_THR;
    if (en[1] && (s.ident[0] || s.ident == ID_MSI || s.ident == ID_THR)) begin
      r.ident = ID_THR;
      r.irq   = 1'b1;
    end
    return r;
  endfunction

  function automatic irq_t reevaluate(irq_t s, logic [3:0] en);
    irq_t r;
    r = s;
    if (s.pend[0] && en[0]) begin
      r = raise_rx(s, en);
    end else if (s.pend[1] && en[1]) begin
      r = raise_tx(s, en);
    end else begin
      r.ident = ID_NONE;
      r.irq   = 1'b0;
    end
    return r;
  endfunction

  // drop a pending bit; re-evaluate only if that source was the one shown
  function automatic irq_t clear_source(irq_t s, logic [3:0] en, logic [1:0] src,
                                        logic [3:0] shown);
    irq_t r;
    r = s;
    r.pend = s.pend & ~src;
    if (s.ident == shown) begin
      r = reevaluate(r, en);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/uartr_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uartr_in_reg
// Input register: holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module uartr_in_reg
  import uartr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/uartr_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uartr_core
// Register file, interrupt logic; one request per cycle updates state on fire.
// ----------------------------------------------------------------------------
module uartr_core
  import uartr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    result
);

  // fcr and mcr are write-only with no visible effect, so they are not kept
  logic [7:0] line_ctrl,    line_ctrl_next;
  logic       data_ready,   data_ready_next;
  logic [3:0] int_enable,   int_enable_next;
  irq_t       irq,          irq_next;
  logic [7:0] divisor_low,  divisor_low_next;
  logic [7:0] divisor_high, divisor_high_next;
  logic [7:0] rx_hold,      rx_hold_next;

  logic dlab;
  assign dlab = line_ctrl[7];

  always_comb begin
    line_ctrl_next    = line_ctrl;
    data_ready_next   = data_ready;
    int_enable_next   = int_enable;
    irq_next          = irq;
    divisor_low_next  = divisor_low;
    divisor_high_next = divisor_high;
    rx_hold_next      = rx_hold;
    result            = '0;

    unique case (item.req_type)
      REQ_READ: begin
        if (dlab && item.reg_offset == OFS_RBR_DLL) begin
          result.read_data = divisor_low;
        end else if (dlab && item.reg_offset == OFS_IER_DLH) begin
          result.read_data = divisor_high;
        end else begin
          unique case (item.reg_offset)
            OFS_RBR_DLL: begin
              result.read_data = rx_hold;
              rx_hold_next     = '0;
              irq_next = clear_source(irq, int_enable, SRC_NONE, ID_RD);
              irq_next = clear_source(irq_next, int_enable, SRC_TO, ID_TO);
              data_ready_next  = 1'b0;
            end
            OFS_IER_DLH: result.read_data = {4'h0, int_enable};
            OFS_IIR_FCR: begin
              result.read_data = {4'h0, irq.ident} | IIR_TOP;
              if (irq.ident == ID_THR) begin
                irq_next = clear_source(irq, int_enable, SRC_THR, ID_THR);
              end
            end
            OFS_LCR:     result.read_data = line_ctrl;
            OFS_LSR:     result.read_data = LSR_FIXED | {7'h00, data_ready};
            default:     result.read_data = '0;
          endcase
        end
      end
      REQ_WRITE: begin
        if (dlab && item.reg_offset == OFS_RBR_DLL) begin
          divisor_low_next = item.byte_in;
        end else if (dlab && item.reg_offset == OFS_IER_DLH) begin
          divisor_high_next = item.byte_in;
        end else begin
          unique case (item.reg_offset)
            OFS_RBR_DLL: begin
              // transmitter drains at once, thre stays set
              irq_next        = raise_tx(irq, int_enable);
              result.tx_valid = 1'b1;
              result.tx_byte  = item.byte_in;
            end
            OFS_IER_DLH: begin
              int_enable_next = item.byte_in[3:0];
              irq_next        = reevaluate(irq, item.byte_in[3:0]);
            end
            OFS_LCR:     line_ctrl_next = item.byte_in;
            default: ;
          endcase
        end
      end
      REQ_RX: begin
        rx_hold_next    = item.byte_in;
        data_ready_next = 1'b1;
        irq_next = clear_source(irq, int_enable, SRC_TO, ID_TO);
        irq_next = raise_rx(irq_next, int_enable);
      end
      default: ;
    endcase

    result.irq_level = irq_next.irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_ctrl    <= LCR_RESET;
      data_ready   <= 1'b0;
      int_enable   <= '0;
      irq          <= '{ident: ID_NONE, pend: SRC_NONE, irq: 1'b0};
      divisor_low  <= '0;
      divisor_high <= '0;
      rx_hold      <= '0;
    end else if (fire) begin
      line_ctrl    <= line_ctrl_next;
      data_ready   <= data_ready_next;
      int_enable   <= int_enable_next;
      irq          <= irq_next;
      divisor_low  <= divisor_low_next;
      divisor_high <= divisor_high_next;
      rx_hold      <= rx_hold_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/uartr_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uartr_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module uartr_out_reg
  import uartr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/uart_register_interrupt_model_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_register_interrupt_model_top
// 16550-style UART register block with level interrupt output.
// ----------------------------------------------------------------------------
// path: input register, then result register, from input transfer to result valid
// throughput: one request per cycle if output free; the register update is one logic pass
// reset: synchronous rst clears both pipeline stages and loads the register reset values
// ----------------------------------------------------------------------------
module uart_register_interrupt_model_top
  import uartr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // reg_offset[2:0], byte_in[10:3], zero pad
  input  wire logic [1:0]  s_tuser,  // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // read_data[7:0], tx_byte[15:8], irq_level[16], pad
  output logic [0:0]       m_tuser   // tx_valid[0]
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    space;
  logic    fire;
  result_t result;
  result_t out_result;

  assign in_item.req_type   = s_tuser;
  assign in_item.reg_offset = s_tdata[2:0];
  assign in_item.byte_in    = s_tdata[10:3];

  assign fire = item_valid && space;

  uartr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (space),
    .item_valid (item_valid),
    .item       (item)
  );

  uartr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  uartr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .result     (result),
    .space      (space),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tdata = {7'h00, out_result.irq_level, out_result.tx_byte, out_result.read_data};
  assign m_tuser = out_result.tx_valid;

  // a transmitting write never carries read data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'h00)
    else $error("read data on a transmit result");

  // tx byte is zero unless a byte was sent
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:8] == 8'h00)
    else $error("tx byte without tx_valid");

  // input side only stalls behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output free");

  // reset empties the result stage
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ----- dv/tb_uart_register_interrupt_model_top.sv -----
// ----------------------------------------------------------------------------
// tb_uart_register_interrupt_model_top
// Stream testbench for the UART register block. Bus reads, bus writes,
// received characters and spare requests are driven on the input stream,
// and a scoreboard predicts the register and interrupt state. Each reply is
// checked field by field, with random idling on both streams and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_uart_register_interrupt_model_top;
  timeunit 1ns;
  timeprecision 1ps;
  import uartr_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [2:0] OFS_MCR   = 3'd4;
  localparam logic [2:0] OFS_SCR   = 3'd7;
  localparam logic [7:0] LSR_DR    = 8'h01;
  localparam logic [7:0] LSR_THRE  = 8'h20;
  localparam logic [7:0] LCR_DLAB  = 8'h80;

  localparam int ITEM_TOTAL  = 1350;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AFTER  = 300;
  localparam int IDLE_LIMIT  = 2000;

  class uart_reg_scoreboard;
    logic [7:0] lcr, lsr, dll, dlm, fcr, mcr, rbr;
    logic [3:0] ier, iid;
    logic [1:0] pend;
    logic       irq;
    result_t    expected_replies[$];
    int errors, n_read, n_write, n_rx, n_spare, n_tx, n_irq;

    function new();
      lcr = LCR_RESET;
      lsr = LSR_FIXED;
      dll = '0;
      dlm = '0;
      fcr = '0;
      mcr = '0;
      rbr = '0;
      ier = '0;
      iid = ID_NONE;
      pend = SRC_NONE;
      irq = 1'b0;
      errors = 0;
      n_read = 0;
      n_write = 0;
      n_rx = 0;
      n_spare = 0;
      n_tx = 0;
      n_irq = 0;
    endfunction

    // receive source only takes over when enabled and no line status/data id shown
    function void flag_rx();
      pend = pend | SRC_TO;
      if (ier[0] && iid != ID_RLS && iid != ID_RD) begin
        iid = ID_TO;
        irq = 1'b1;
      end
    endfunction

    function void flag_tx();
      pend = pend | SRC_THR;
      if (ier[1] && (iid[0] || iid == ID_MSI || iid == ID_THR)) begin
        iid = ID_THR;
        irq = 1'b1;
      end
    endfunction

    function void rescan();
      if (pend[0] && ier[0]) begin
        flag_rx();
      end else if (pend[1] && ier[1]) begin
        flag_tx();
      end else begin
        iid = ID_NONE;
        irq = 1'b0;
      end
    endfunction

    function void drop_source(logic [1:0] src, logic [3:0] shown);
      pend = pend & ~src;
      if (iid == shown) rescan();
    endfunction

    function result_t apply_request(item_t it);
      result_t r;
      r = '0;
      case (it.req_type)
        REQ_READ: begin
          n_read++;
          if (lcr[7] && it.reg_offset == OFS_RBR_DLL) begin
            r.read_data = dll;
          end else if (lcr[7] && it.reg_offset == OFS_IER_DLH) begin
            r.read_data = dlm;
          end else begin
            case (it.reg_offset)
              OFS_RBR_DLL: begin
                r.read_data = rbr;
                rbr = '0;
                drop_source(SRC_NONE, ID_RD);
                drop_source(SRC_TO, ID_TO);
                lsr = lsr & ~LSR_DR;
              end
              OFS_IER_DLH: r.read_data = {4'h0, ier};
              OFS_IIR_FCR: begin
                r.read_data = IIR_TOP | {4'h0, iid};
                if (iid == ID_THR) drop_source(SRC_THR, ID_THR);
              end
              OFS_LCR: r.read_data = lcr;
              OFS_LSR: r.read_data = lsr;
              default: r.read_data = '0;
            endcase
          end
        end
        REQ_WRITE: begin
          n_write++;
          if (lcr[7] && it.reg_offset == OFS_RBR_DLL) begin
            dll = it.byte_in;
          end else if (lcr[7] && it.reg_offset == OFS_IER_DLH) begin
            dlm = it.byte_in;
          end else begin
            case (it.reg_offset)
              OFS_RBR_DLL: begin
                lsr = lsr | LSR_THRE;
                flag_tx();
                r.tx_valid = 1'b1;
                r.tx_byte = it.byte_in;
              end
              OFS_IER_DLH: begin
                ier = it.byte_in[3:0];
                rescan();
              end
              OFS_IIR_FCR: fcr = it.byte_in;
              OFS_LCR:     lcr = it.byte_in;
              OFS_MCR:     mcr = it.byte_in;
              default: ;
            endcase
          end
        end
        REQ_RX: begin
          n_rx++;
          rbr = it.byte_in;
          drop_source(SRC_TO, ID_TO);
          lsr = lsr | LSR_DR;
          flag_rx();
        end
        default: n_spare++;
      endcase
      r.irq_level = irq;
      if (r.tx_valid) n_tx++;
      if (r.irq_level) n_irq++;
      return r;
    endfunction

    function void note_request(item_t it);
      expected_replies.push_back(apply_request(it));
    endfunction

    function void report(string name, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t ns: reply with none expected, expected nothing actual %h", $time, got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
      if (got.tx_valid !== want.tx_valid)
        report("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
      if (got.irq_level !== want.irq_level)
        report("irq_level", 8'(want.irq_level), 8'(got.irq_level));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // reg_offset[2:0], byte_in[10:3], zero pad
  logic [1:0]  s_tuser = '0;  // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // read_data[7:0], tx_byte[15:8], irq_level[16], pad
  logic [0:0]  m_tuser;       // tx_valid[0]

  uart_reg_scoreboard sb = new();
  int items_sent = 0;
  int quiet_cycles = 0;
  bit sender_pauses = 1'b1;
  bit reader_stalls = 1'b1;
  bit calm = 1'b0;
  bit held_off = 1'b0;

  uart_register_interrupt_model_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_item(item_t it);
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, it.byte_in, it.reg_offset};
    s_tuser <= it.req_type;
    do @(posedge clk); while (!s_tready);
    sb.note_request(it);
    items_sent++;
    if (sender_pauses && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic issue(logic [1:0] kind, logic [2:0] ofs, logic [7:0] b);
    item_t it;
    it.req_type = kind;
    it.reg_offset = ofs;
    it.byte_in = b;
    send_item(it);
  endtask

  task automatic random_access();
    int pick;
    logic [2:0] ofs;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    ofs = 3'($urandom_range(0, 7));
    b = 8'($urandom_range(0, 255));
    if (pick < 22) begin
      issue(REQ_RX, ofs, b);
    end else if (pick < 50) begin
      // lean on data and ident reads, they clear sources
      if (pick < 36) ofs = pick[0] ? OFS_RBR_DLL : OFS_IIR_FCR;
      issue(REQ_READ, ofs, b);
    end else if (pick < 88) begin
      if (pick < 60) ofs = OFS_RBR_DLL;
      else if (pick < 70) ofs = OFS_IER_DLH;
      // keep the latch bit mostly clear so data/ier accesses dominate
      if (ofs == OFS_LCR && $urandom_range(0, 3) != 0) b = b & ~LCR_DLAB;
      issue(REQ_WRITE, ofs, b);
    end else if (pick < 93) begin
      issue(REQ_SPARE, ofs, b);
    end else begin
      // full divisor programming sequence
      issue(REQ_WRITE, OFS_LCR, b | LCR_DLAB);
      issue(REQ_WRITE, OFS_RBR_DLL, 8'($urandom_range(0, 255)));
      issue(REQ_WRITE, OFS_IER_DLH, 8'($urandom_range(0, 255)));
      issue(REQ_READ, OFS_RBR_DLL, 8'($urandom_range(0, 255)));
      issue(REQ_READ, OFS_IER_DLH, 8'($urandom_range(0, 255)));
      issue(REQ_WRITE, OFS_LCR, b & ~LCR_DLAB);
    end
  endtask

  // output side: random stalls, one long hold-off, no stalls near the end
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && items_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || !reader_stalls || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : reply_monitor
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tuser[0], m_tdata[15:8], m_tdata[16]};
      sb.check_reply(got);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("uart_register_interrupt_model_top verification failed");
      $finish;
    end
  end

  initial begin
    int next_phase;
    next_phase = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values of every offset
    for (int i = 0; i < 8; i++) issue(REQ_READ, i[2:0], 8'h00);
    issue(REQ_WRITE, OFS_IER_DLH, 8'hFF);
    issue(REQ_WRITE, OFS_RBR_DLL, 8'hFF);
    issue(REQ_READ, OFS_IIR_FCR, 8'h00);
    issue(REQ_WRITE, OFS_RBR_DLL, 8'h00);
    issue(REQ_RX, OFS_SCR, 8'h00);
    // transmit while receive is shown
    issue(REQ_WRITE, OFS_RBR_DLL, 8'h5A);
    issue(REQ_READ, OFS_IIR_FCR, 8'h00);
    issue(REQ_RX, OFS_RBR_DLL, 8'hFF);
    issue(REQ_READ, OFS_RBR_DLL, 8'h00);
    // fifo clear has no effect
    issue(REQ_WRITE, OFS_IIR_FCR, 8'h07);
    issue(REQ_WRITE, OFS_MCR, 8'hFF);
    for (int i = 5; i < 8; i++) issue(REQ_WRITE, i[2:0], 8'hFF);
    issue(REQ_WRITE, OFS_LCR, 8'h83);
    issue(REQ_WRITE, OFS_RBR_DLL, 8'hFF);
    issue(REQ_WRITE, OFS_IER_DLH, 8'h00);
    issue(REQ_READ, OFS_RBR_DLL, 8'h00);
    issue(REQ_WRITE, OFS_LCR, 8'h00);
    issue(REQ_SPARE, OFS_SCR, 8'hFF);
    issue(REQ_WRITE, OFS_IER_DLH, 8'h00);

    while (items_sent < ITEM_TOTAL) begin
      if (items_sent >= next_phase) begin
        next_phase = items_sent + 100;
        sender_pauses = $urandom_range(0, 2) != 0;
        reader_stalls = $urandom_range(0, 2) != 0;
      end
      if (items_sent >= ITEM_TOTAL - CALM_ITEMS) begin
        sender_pauses = 1'b0;
        calm = 1'b1;
      end
      random_access();
    end
    s_tvalid <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    $display("covered %0d reads, %0d writes, %0d received characters, %0d spare requests",
             sb.n_read, sb.n_write, sb.n_rx, sb.n_spare);
    $display("%0d bytes transmitted, %0d replies with the interrupt line high",
             sb.n_tx, sb.n_irq);
    if (sb.errors == 0) begin
      $display("uart_register_interrupt_model_top verification clean");
    end else begin
      $display("uart_register_interrupt_model_top verification failed");
    end
    $finish;
  end

endmodule
